/* rtl/core/selu_pkg.sv */
// shared types and constants for the selection to utf-8 serializer
`timescale 1ns / 1ps

package selu_pkg;

    localparam int ROW_LIMIT   = 4096;
    localparam int COL_LIMIT   = 1024;
    localparam int QUEUE_DEPTH = 2;

    localparam int ROW_W   = 12;
    localparam int COL_W   = 10;
    localparam int CP_W    = 21;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 12;
    localparam int NSLOT   = 5;
    localparam int SLOT_W  = 3;

    localparam logic [IDX_W-1:0] REG_CORNER_A_ROW     = 3'd0;
    localparam logic [IDX_W-1:0] REG_CORNER_A_COL     = 3'd1;
    localparam logic [IDX_W-1:0] REG_CORNER_B_ROW     = 3'd2;
    localparam logic [IDX_W-1:0] REG_CORNER_B_COL     = 3'd3;
    localparam logic [IDX_W-1:0] REG_SELECTION_ACTIVE = 3'd4;

    localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_ONE_MAX  = 21'h000080;
    localparam logic [CP_W-1:0] CP_TWO_MAX  = 21'h000800;
    localparam logic [CP_W-1:0] CP_THREE_MAX = 21'h010000;

    localparam logic [7:0] LEAD2    = 8'hC0;
    localparam logic [7:0] LEAD3    = 8'hE0;
    localparam logic [7:0] LEAD4    = 8'hF0;
    localparam logic [7:0] CONT     = 8'h80;
    localparam logic [7:0] NL_BYTE  = 8'h0A;

    typedef struct packed {
        logic [NSLOT-1:0][7:0] bytes;
        logic [SLOT_W-1:0]     last_idx;
        logic                  sel_last;
    } entry_t;

endpackage

/* rtl/core/selu_front.sv */
// front end: configuration, position counters and utf-8 classification
`timescale 1ns / 1ps

module selu_front
    import selu_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CP_W-1:0]   s_codepoint,
    output logic              q_push,
    output entry_t            q_entry,
    input  logic              q_full
);

    logic [ROW_W-1:0] a_row_reg, a_row_next, b_row_reg, b_row_next;
    logic [COL_W-1:0] a_col_reg, a_col_next, b_col_reg, b_col_next;
    logic             active_reg, active_next;
    logic [COL_W-1:0] col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;

    logic [ROW_W-1:0] ar, br, row_span;
    logic [COL_W-1:0] ac, bc, col_span;
    logic             last_col, last_row, accept, cfg_hit;
    logic [CP_W-1:0]  cp;
    logic [3:0][7:0]  enc;
    logic [SLOT_W-1:0] nb;

    assign ar = (32'(a_row_reg) >= ROW_LIMIT) ? ROW_W'(ROW_LIMIT - 1) : a_row_reg;
    assign br = (32'(b_row_reg) >= ROW_LIMIT) ? ROW_W'(ROW_LIMIT - 1) : b_row_reg;
    assign ac = (32'(a_col_reg) >= COL_LIMIT) ? COL_W'(COL_LIMIT - 1) : a_col_reg;
    assign bc = (32'(b_col_reg) >= COL_LIMIT) ? COL_W'(COL_LIMIT - 1) : b_col_reg;
    assign row_span = (ar < br) ? (br - ar) : (ar - br);
    assign col_span = (ac < bc) ? (bc - ac) : (ac - bc);

    assign last_col = col_cnt_reg >= col_span;
    assign last_row = row_cnt_reg >= row_span;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && active_reg;
    assign cfg_hit = cfg_wr_en && (cfg_index <= REG_SELECTION_ACTIVE);

    assign cp = (s_codepoint > CP_MAX) ? CP_MAX : s_codepoint;

    always_comb begin
        enc = '0;
        if (cp < CP_ONE_MAX) begin
            enc[0] = cp[7:0];
            nb     = SLOT_W'(1);
        end else if (cp < CP_TWO_MAX) begin
            enc[0] = LEAD2 | {3'b000, cp[10:6]};
            enc[1] = CONT | {2'b00, cp[5:0]};
            nb     = SLOT_W'(2);
        end else if (cp < CP_THREE_MAX) begin
            enc[0] = LEAD3 | {4'b0000, cp[15:12]};
            enc[1] = CONT | {2'b00, cp[11:6]};
            enc[2] = CONT | {2'b00, cp[5:0]};
            nb     = SLOT_W'(3);
        end else begin
            enc[0] = LEAD4 | {5'b00000, cp[20:18]};
            enc[1] = CONT | {2'b00, cp[17:12]};
            enc[2] = CONT | {2'b00, cp[11:6]};
            enc[3] = CONT | {2'b00, cp[5:0]};
            nb     = SLOT_W'(4);
        end
    end

    always_comb begin
        q_entry          = '0;
        q_entry.bytes[3:0] = enc;
        q_entry.sel_last = last_col && last_row;
        if (last_col && !last_row) begin
            q_entry.bytes[nb] = NL_BYTE;
            q_entry.last_idx  = nb;
        end else begin
            q_entry.last_idx  = nb - SLOT_W'(1);
        end
    end

    always_comb begin
        a_row_next  = a_row_reg;
        a_col_next  = a_col_reg;
        b_row_next  = b_row_reg;
        b_col_next  = b_col_reg;
        active_next = active_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CORNER_A_ROW:     a_row_next  = cfg_wdata[ROW_W-1:0];
                REG_CORNER_A_COL:     a_col_next  = cfg_wdata[COL_W-1:0];
                REG_CORNER_B_ROW:     b_row_next  = cfg_wdata[ROW_W-1:0];
                REG_CORNER_B_COL:     b_col_next  = cfg_wdata[COL_W-1:0];
                REG_SELECTION_ACTIVE: active_next = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (cfg_hit) begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end else if (q_push) begin
            if (last_col) begin
                col_cnt_next = '0;
                row_cnt_next = last_row ? '0 : row_cnt_reg + ROW_W'(1);
            end else begin
                col_cnt_next = col_cnt_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_row_reg   <= '0;
            a_col_reg   <= '0;
            b_row_reg   <= '0;
            b_col_reg   <= '0;
            active_reg  <= 1'b0;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else begin
            a_row_reg   <= a_row_next;
            a_col_reg   <= a_col_next;
            b_row_reg   <= b_row_next;
            b_col_reg   <= b_col_next;
            active_reg  <= active_next;
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_in_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_cnt_reg <= col_span) && (row_cnt_reg <= row_span))
        else $error("position counter outside selection");
`endif

endmodule

/* rtl/core/selu_fifo.sv */
// short queue of classified cells between front and back
`timescale 1ns / 1ps

module selu_fifo
    import selu_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    output logic   q_valid,
    output entry_t q_entry,
    input  logic   pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full    = count_reg == CNT_W'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid)
        else $error("queue read while empty");
`endif

endmodule

/* rtl/core/selu_back.sv */
// back end: steps through the bytes of each cell into the output register
`timescale 1ns / 1ps

module selu_back
    import selu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  entry_t     q_entry,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_cell_done,
    output logic       m_selection_done
);

    logic              cur_valid_reg, cur_valid_next;
    entry_t            cur_entry_reg, cur_entry_next;
    logic [SLOT_W-1:0] cur_idx_reg, cur_idx_next;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        byte_reg, byte_next;
    logic              cell_done_reg, cell_done_next;
    logic              sel_done_reg, sel_done_next;
    logic              out_load, cur_last;

    assign out_load = cur_valid_reg && (!m_valid_reg || m_ready);
    assign cur_last = cur_idx_reg == cur_entry_reg.last_idx;
    assign q_pop    = q_valid && (!cur_valid_reg || (out_load && cur_last));

    always_comb begin
        cur_valid_next = cur_valid_reg;
        cur_entry_next = cur_entry_reg;
        cur_idx_next   = cur_idx_reg;
        if (q_pop) begin
            cur_valid_next = 1'b1;
            cur_entry_next = q_entry;
            cur_idx_next   = '0;
        end else if (out_load && cur_last) begin
            cur_valid_next = 1'b0;
        end else if (out_load) begin
            cur_idx_next = cur_idx_reg + SLOT_W'(1);
        end
    end

    always_comb begin
        m_valid_next   = m_valid_reg;
        byte_next      = byte_reg;
        cell_done_next = cell_done_reg;
        sel_done_next  = sel_done_reg;
        if (out_load) begin
            m_valid_next   = 1'b1;
            byte_next      = cur_entry_reg.bytes[cur_idx_reg];
            cell_done_next = cur_last;
            sel_done_next  = cur_last && cur_entry_reg.sel_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        cur_entry_reg <= cur_entry_next;
        cur_idx_reg   <= cur_idx_next;
        byte_reg      <= byte_next;
        cell_done_reg <= cell_done_next;
        sel_done_reg  <= sel_done_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_byte       = byte_reg;
    assign m_cell_done      = cell_done_reg;
    assign m_selection_done = sel_done_reg;

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> (cur_idx_reg <= cur_entry_reg.last_idx))
        else $error("byte index past end of cell");
    a_sel_done_on_cell_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && sel_done_reg) |-> cell_done_reg)
        else $error("selection end not on a cell end");
`endif

endmodule

/* rtl/core/selection_to_utf8_serializer_core.sv */
// top level of the rectangular selection to utf-8 serializer
//
// usage:
//   s_ channel: one transaction per selected cell, codepoint in row-major order
//   m_ channel: one transaction per output byte, with cell_done on the last
//     byte of a cell (the newline when a row other than the last ends) and
//     selection_done on the final byte of the whole selection
//   cfg port: cfg_wr_en/cfg_index/cfg_wdata write corners and selection_active;
//     any write to a defined register restarts the selection at its first cell
//   path: queue, then the stepper's cell register, then the output register
//   throughput: one byte per cycle from the byte stepper while the receiver
//     is ready; a cell is 1 to 5 bytes (utf-8 length plus optional newline)
//   a 2-entry queue decouples the input from the byte stepper; while the
//     receiver stalls the output register holds and input stops once the
//     queue and the stepper are full
//   with no active selection input transactions are taken and dropped
//   reset clears the registers, counters, queue and output valid
`timescale 1ns / 1ps

module selection_to_utf8_serializer_core
    import selu_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CP_W-1:0]   s_codepoint,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic              m_cell_done,
    output logic              m_selection_done
);

    logic   push, full, q_valid, pop;
    entry_t push_entry, q_entry;

    selu_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_codepoint (s_codepoint),
        .q_push      (push),
        .q_entry     (push_entry),
        .q_full      (full)
    );

    selu_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .pop        (pop)
    );

    selu_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_entry          (q_entry),
        .q_pop            (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_cell_done      (m_cell_done),
        .m_selection_done (m_selection_done)
    );

endmodule
